>>> src/ubds_pkg.sv
package ubds_pkg;

  localparam int CLK_W   = 32;
  localparam int BAUD_W  = 32;
  localparam int OSR_W   = 4;
  localparam int DIV_W   = 16;
  localparam int ERR_W   = 32;
  localparam int QUO_W   = 32;
  localparam int DEN_W   = 36;
  localparam int DIV_STEPS = 2;

  // One oversample trial on its way into the first divider
  typedef struct packed {
    logic [BAUD_W-1:0] baud;
    logic [CLK_W-1:0]  clk_hz;
    logic [OSR_W-1:0]  osr;
    logic              first;
    logic              last;
    logic              kill;
  } job_t;

  // One trial on its way through the second divider
  typedef struct packed {
    logic [BAUD_W-1:0] baud;
    logic [OSR_W-1:0]  osr;
    logic [DIV_W-1:0]  div_m1;
    logic              fit;
    logic              first;
    logic              last;
  } fit_t;

  // (osr + 1) * v, exact in DEN_W bits for a 32-bit v
  function automatic logic [DEN_W-1:0] mul_samples(input logic [OSR_W-1:0] osr,
                                                   input logic [31:0] v);
    logic [DEN_W:0] p;
    p = ({33'd0, osr} + 37'd1) * {5'd0, v};
    return p[DEN_W-1:0];
  endfunction

endpackage

>>> src/ubds_div_pipe.sv
module ubds_div_pipe
  import ubds_pkg::*;
#(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_vld,
  input  logic [QUO_W-1:0]  in_num,
  input  logic [DEN_W-1:0]  in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_vld,
  output logic [QUO_W-1:0]  out_quo,
  output logic [SIDE_W-1:0] out_side
);

  localparam int STAGES = QUO_W / DIV_STEPS;

  logic [STAGES-1:0]      vld_r;
  logic [DEN_W-1:0]       rem_r  [STAGES];
  logic [QUO_W-1:0]       num_r  [STAGES];
  logic [QUO_W-1:0]       quo_r  [STAGES];
  logic [DEN_W-1:0]       den_r  [STAGES];
  logic [SIDE_W-1:0]      side_r [STAGES];
  logic [DEN_W-1:0]       rem_nxt [STAGES];
  logic [QUO_W-1:0]       num_nxt [STAGES];
  logic [QUO_W-1:0]       quo_nxt [STAGES];

  // Restoring division, DIV_STEPS quotient bits per stage
  always_comb begin
    logic [DEN_W-1:0] r;
    logic [DEN_W:0]   t;
    logic [QUO_W-1:0] n;
    logic [QUO_W-1:0] q;
    logic [DEN_W-1:0] d;
    for (int k = 0; k < STAGES; k++) begin
      if (k == 0) begin
        r = '0;
        n = in_num;
        q = '0;
        d = in_den;
      end else begin
        r = rem_r[k-1];
        n = num_r[k-1];
        q = quo_r[k-1];
        d = den_r[k-1];
      end
      for (int j = 0; j < DIV_STEPS; j++) begin
        t = {r, n[QUO_W-1]};
        n = {n[QUO_W-2:0], 1'b0};
        if (t >= {1'b0, d}) begin
          t = t - {1'b0, d};
          q = {q[QUO_W-2:0], 1'b1};
        end else begin
          q = {q[QUO_W-2:0], 1'b0};
        end
        r = t[DEN_W-1:0];
      end
      rem_nxt[k] = r;
      num_nxt[k] = n;
      quo_nxt[k] = q;
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[STAGES-2:0], in_vld};
    end
  end

  // Advance data
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < STAGES; k++) begin
        rem_r[k] <= rem_nxt[k];
        num_r[k] <= num_nxt[k];
        quo_r[k] <= quo_nxt[k];
        if (k == 0) begin
          den_r[k]  <= in_den;
          side_r[k] <= in_side;
        end else begin
          den_r[k]  <= den_r[k-1];
          side_r[k] <= side_r[k-1];
        end
      end
    end
  end

  assign out_vld  = vld_r[STAGES-1];
  assign out_quo  = quo_r[STAGES-1];
  assign out_side = side_r[STAGES-1];

endmodule

>>> src/uart_baud_divisor_search.sv
// A new transaction is accepted as the last oversample trial of the previous one issues,
// so transactions overlap in the pipeline; each oversample trial takes one slot in each
// divider pipeline, and all stages hold while the output is stalled.
// Two 16-stage dividers (2 quotient bits per stage) set the latency.
// Synchronous active-low reset clears all valid bits and sets clock_hz to 12000000.
module uart_baud_divisor_search
  import ubds_pkg::*;
#(
  parameter int OVERSAMPLE_MAX = 15,
  parameter int OVERSAMPLE_MIN = 8,
  parameter int DIVISOR_BITS   = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [CLK_W-1:0]  cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BAUD_W-1:0] in_target_baud,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [OSR_W-1:0]  out_oversample_setting,
  output logic [DIV_W-1:0]  out_divisor_value,
  output logic [ERR_W-1:0]  out_rate_error,
  output logic              out_no_fit
);

  localparam logic [OSR_W-1:0] OS_MAX = OSR_W'(OVERSAMPLE_MAX);
  localparam logic [OSR_W-1:0] OS_MIN = OSR_W'(OVERSAMPLE_MIN);
  localparam logic RANGE_EMPTY = (OVERSAMPLE_MIN > OVERSAMPLE_MAX);
  localparam logic [QUO_W-1:0] QMAX = {{(QUO_W-1){1'b0}}, 1'b1} << DIVISOR_BITS;
  localparam int JOB_W = $bits(job_t);
  localparam int FIT_W = $bits(fit_t);

  logic [CLK_W-1:0] clock_hz_r;
  logic             adv;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_hz_r <= CLK_W'(12000000);
    end else if (cfg_wr_en) begin
      clock_hz_r <= cfg_wr_data;
    end
  end

  // Trial sequencer: one oversample setting issued per advancing cycle
  logic              seq_vld_r;
  logic [BAUD_W-1:0] seq_baud_r;
  logic [CLK_W-1:0]  seq_clk_r;
  logic [OSR_W-1:0]  seq_osr_r;
  logic              seq_first_r;
  logic              seq_last;
  logic              in_take;

  assign seq_last = RANGE_EMPTY || (seq_osr_r == OS_MIN);
  assign in_stall = seq_vld_r && !(seq_last && adv);
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_vld_r <= 1'b0;
    end else if (in_take) begin
      seq_vld_r <= 1'b1;
    end else if (adv && seq_last) begin
      seq_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      seq_baud_r  <= in_target_baud;
      seq_clk_r   <= clock_hz_r;
      seq_osr_r   <= OS_MAX;
      seq_first_r <= 1'b1;
    end else if (adv) begin
      seq_osr_r   <= seq_osr_r - OSR_W'(1);
      seq_first_r <= 1'b0;
    end
  end

  // Stage A: divisor (osr+1)*baud
  logic             a_vld_r;
  logic [DEN_W-1:0] a_den_r;
  job_t             a_job_r;
  job_t             seq_job;

  always_comb begin
    seq_job.baud   = seq_baud_r;
    seq_job.clk_hz = seq_clk_r;
    seq_job.osr    = seq_osr_r;
    seq_job.first  = seq_first_r;
    seq_job.last   = seq_last;
    seq_job.kill   = RANGE_EMPTY || (seq_baud_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= seq_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_den_r <= mul_samples(seq_osr_r, seq_baud_r);
      a_job_r <= seq_job;
    end
  end

  // First divider: q = clock / ((osr+1)*baud)
  logic             d1_vld;
  logic [QUO_W-1:0] d1_quo;
  logic [JOB_W-1:0] d1_side;
  job_t             d1_job;

  ubds_div_pipe #(.SIDE_W(JOB_W)) u_div_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (a_vld_r),
    .in_num   (a_job_r.clk_hz),
    .in_den   (a_den_r),
    .in_side  (a_job_r),
    .out_vld  (d1_vld),
    .out_quo  (d1_quo),
    .out_side (d1_side)
  );

  assign d1_job = job_t'(d1_side);

  // Stage B: range check and divisor (osr+1)*q
  logic             b_vld_r;
  logic [CLK_W-1:0] b_clk_r;
  logic [DEN_W-1:0] b_den_r;
  fit_t             b_fit_r;
  fit_t             b_fit;
  logic [QUO_W-1:0] q_m1;
  logic [QUO_W-1:0] q_use;

  always_comb begin
    q_m1          = d1_quo - QUO_W'(1);
    b_fit.baud    = d1_job.baud;
    b_fit.osr     = d1_job.osr;
    b_fit.div_m1  = q_m1[DIV_W-1:0];
    b_fit.fit     = !d1_job.kill && (d1_quo != '0) && (d1_quo <= QMAX);
    b_fit.first   = d1_job.first;
    b_fit.last    = d1_job.last;
    q_use         = b_fit.fit ? d1_quo : QUO_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (adv) begin
      b_vld_r <= d1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_clk_r <= d1_job.clk_hz;
      b_den_r <= mul_samples(d1_job.osr, q_use);
      b_fit_r <= b_fit;
    end
  end

  // Second divider: achieved = clock / ((osr+1)*q)
  logic             d2_vld;
  logic [QUO_W-1:0] d2_quo;
  logic [FIT_W-1:0] d2_side;
  fit_t             d2_fit;

  ubds_div_pipe #(.SIDE_W(FIT_W)) u_div_rate (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (b_vld_r),
    .in_num   (b_clk_r),
    .in_den   (b_den_r),
    .in_side  (b_fit_r),
    .out_vld  (d2_vld),
    .out_quo  (d2_quo),
    .out_side (d2_side)
  );

  assign d2_fit = fit_t'(d2_side);

  // Stage C: absolute rate error
  logic             c_vld_r;
  logic [ERR_W-1:0] c_err_r;
  fit_t             c_fit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (adv) begin
      c_vld_r <= d2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_err_r <= (d2_quo > d2_fit.baud) ? (d2_quo - d2_fit.baud) : (d2_fit.baud - d2_quo);
      c_fit_r <= d2_fit;
    end
  end

  // Keep the best trial; strict compare lets the higher setting win a tie
  logic             best_found_r;
  logic [ERR_W-1:0] best_err_r;
  logic [OSR_W-1:0] best_osr_r;
  logic [DIV_W-1:0] best_div_r;
  logic             base_found;
  logic             take;
  logic             new_found;
  logic [ERR_W-1:0] new_err;
  logic [OSR_W-1:0] new_osr;
  logic [DIV_W-1:0] new_div;

  always_comb begin
    base_found = !c_fit_r.first && best_found_r;
    take       = c_fit_r.fit && (!base_found || (c_err_r < best_err_r));
    new_found  = take || base_found;
    new_err    = take ? c_err_r : best_err_r;
    new_osr    = take ? c_fit_r.osr : best_osr_r;
    new_div    = take ? c_fit_r.div_m1 : best_div_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_found_r <= 1'b0;
    end else if (adv && c_vld_r) begin
      best_found_r <= new_found;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && c_vld_r) begin
      best_err_r <= new_err;
      best_osr_r <= new_osr;
      best_div_r <= new_div;
    end
  end

  // Output register; the pipeline advances whenever it is free or being taken
  logic             out_valid_r;
  logic [OSR_W-1:0] out_osr_r;
  logic [DIV_W-1:0] out_div_r;
  logic [ERR_W-1:0] out_err_r;
  logic             out_nofit_r;

  assign adv = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && c_vld_r && c_fit_r.last) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && c_vld_r && c_fit_r.last) begin
      out_osr_r   <= new_found ? new_osr : '0;
      out_div_r   <= new_found ? new_div : '0;
      out_err_r   <= new_found ? new_err : '0;
      out_nofit_r <= !new_found;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_oversample_setting = out_osr_r;
  assign out_divisor_value      = out_div_r;
  assign out_rate_error         = out_err_r;
  assign out_no_fit             = out_nofit_r;

  // Checks
  a_idle_takes_input: assert property (@(posedge clk) disable iff (!rst_n)
    !seq_vld_r |-> !in_stall)
    else $error("input stalled with an idle sequencer");

  a_nofit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_no_fit) |->
      (out_oversample_setting == '0 && out_divisor_value == '0 && out_rate_error == '0))
    else $error("no-fit result carries nonzero fields");

  a_fit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_no_fit) |->
      (out_oversample_setting >= OS_MIN && out_oversample_setting <= OS_MAX))
    else $error("chosen oversample setting outside the searched range");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(c_vld_r))
    else $error("pipeline moved while the output was blocked");

endmodule

>>> tb/tb_uart_baud_divisor_search.sv
module tb_uart_baud_divisor_search;
  import ubds_pkg::*;

  localparam int OSR_HI   = 15;
  localparam int OSR_LO   = 8;
  localparam int QUO_BITS = 16;
  localparam int RESET_CLOCK_HZ = 12000000;
  localparam int LATENCY  = 60;

  // Shape of one directed row
  typedef enum logic [1:0] {CHK_PREDICT, CHK_NO_FIT} row_kind_t;

  typedef struct packed {
    logic [OSR_W-1:0] osr;
    logic [DIV_W-1:0] div;
    logic [ERR_W-1:0] err;
    logic             no_fit;
  } pick_t;

  typedef struct {
    logic [BAUD_W-1:0] baud;
    row_kind_t         kind;
  } row_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [CLK_W-1:0]  cfg_wr_data;
  logic              in_valid;
  logic              in_stall;
  logic [BAUD_W-1:0] in_target_baud;
  logic              out_valid;
  logic              out_stall;
  logic [OSR_W-1:0]  out_oversample_setting;
  logic [DIV_W-1:0]  out_divisor_value;
  logic [ERR_W-1:0]  out_rate_error;
  logic              out_no_fit;

  logic [CLK_W-1:0] clock_hz_model;
  pick_t            pending_picks[$];
  int               fail_count;
  int               send_idle_pct;
  int               recv_idle_pct;

  uart_baud_divisor_search dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_target_baud(in_target_baud),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_oversample_setting(out_oversample_setting),
    .out_divisor_value(out_divisor_value),
    .out_rate_error(out_rate_error), .out_no_fit(out_no_fit)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // Search the oversample settings for the smallest baud error
  function automatic pick_t best_divisor(input logic [CLK_W-1:0] fclk,
                                         input logic [BAUD_W-1:0] baud);
    pick_t  p;
    logic [63:0] q, got, e, best_e;
    logic   found;
    p = '0;
    found = 1'b0;
    best_e = '0;
    if (baud != 0) begin
      for (int s = OSR_HI; s >= OSR_LO; s--) begin
        q = 64'(fclk) / (64'(s + 1) * 64'(baud));
        if (q != 0 && q <= (64'd1 << QUO_BITS)) begin
          got = 64'(fclk) / (64'(s + 1) * q);
          e = (got > baud) ? got - baud : 64'(baud) - got;
          if (!found || e < best_e) begin
            found = 1'b1;
            best_e = e;
            p.osr = OSR_W'(s);
            p.div = DIV_W'(q - 1);
            p.err = ERR_W'(e);
          end
        end
      end
    end
    if (!found) p = '{osr: '0, div: '0, err: '0, no_fit: 1'b1};
    return p;
  endfunction

  // Pick a sender or receiver idle decision for the next cycle
  function automatic bit roll(input int pct);
    return $urandom_range(99, 0) < pct;
  endfunction

  // Drive one transaction and hold it until accepted
  task automatic send_baud(input logic [BAUD_W-1:0] baud, input row_kind_t kind);
    pick_t exp_pick;
    while (roll(send_idle_pct)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_target_baud <= baud;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    exp_pick = best_divisor(clock_hz_model, baud);
    if (kind == CHK_NO_FIT) exp_pick = '{osr: '0, div: '0, err: '0, no_fit: 1'b1};
    pending_picks.push_back(exp_pick);
    @(negedge clk);
  endtask

  // Wait for all results, let the pipeline drain, then write the clock
  task automatic set_clock(input logic [CLK_W-1:0] fclk);
    in_valid <= 1'b0;
    while (pending_picks.size() != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= fclk;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    clock_hz_model = fclk;
  endtask

  // Random baud: mostly near real rates for the clock, sometimes anything
  function automatic logic [BAUD_W-1:0] rand_baud();
    int sel;
    logic [63:0] lim;
    sel = $urandom_range(9, 0);
    lim = 64'(clock_hz_model) / 9;
    if (sel == 0) return $urandom();
    if (sel == 1) return BAUD_W'($urandom_range(3, 0));
    if (lim == 0) return BAUD_W'($urandom_range(2, 1));
    return BAUD_W'(64'($urandom()) % lim + 1);
  endfunction

  // Check each accepted result against the oldest expectation
  always @(posedge clk) begin
    pick_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_picks.size() == 0) begin
        $error("result with no transaction outstanding");
        fail_count++;
      end else begin
        e = pending_picks.pop_front();
        if (out_oversample_setting !== e.osr) begin
          $error("oversample_setting exp %0d got %0d", e.osr, out_oversample_setting);
          fail_count++;
        end
        if (out_divisor_value !== e.div) begin
          $error("divisor_value exp %0d got %0d", e.div, out_divisor_value);
          fail_count++;
        end
        if (out_rate_error !== e.err) begin
          $error("rate_error exp %0d got %0d", e.err, out_rate_error);
          fail_count++;
        end
        if (out_no_fit !== e.no_fit) begin
          $error("no_fit exp %0d got %0d", e.no_fit, out_no_fit);
          fail_count++;
        end
      end
    end
  end

  // Receiver stall, redrawn every falling edge
  always @(negedge clk) begin
    out_stall <= rst_n ? roll(recv_idle_pct) : 1'b0;
  end

  initial begin
    #50_000_000;
    $display("** uart_baud_divisor_search: FAILED **");
    $finish;
  end

  initial begin
    row_t rows[$];
    logic [CLK_W-1:0] clocks[6];
    int n;
    fail_count = 0;
    send_idle_pct = 31;
    recv_idle_pct = 69;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_target_baud = '0;
    out_stall = 1'b0;
    clock_hz_model = RESET_CLOCK_HZ;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed rows at the reset clock: zero baud, extremes, common rates
    rows = '{
      '{32'd0, CHK_NO_FIT}, '{32'hFFFF_FFFF, CHK_NO_FIT}, '{32'd1, CHK_PREDICT},
      '{32'd9600, CHK_PREDICT}, '{32'd115200, CHK_PREDICT}, '{32'd1_500_000, CHK_PREDICT},
      '{32'd750_000, CHK_PREDICT}, '{32'd1_333_334, CHK_NO_FIT}, '{32'd11, CHK_PREDICT},
      '{32'd12, CHK_PREDICT}, '{32'h5555_5555, CHK_NO_FIT}, '{32'hAAAA_AAAA, CHK_NO_FIT},
      '{32'd300, CHK_PREDICT}, '{32'd57600, CHK_PREDICT}
    };
    foreach (rows[i]) send_baud(rows[i].baud, rows[i].kind);

    // Zero clock: nothing fits
    set_clock('0);
    send_baud(32'd9600, CHK_NO_FIT);
    send_baud(32'd1, CHK_NO_FIT);
    // Largest clock: tiny and huge rates do not fit, the others do
    set_clock(32'hFFFF_FFFF);
    send_baud(32'd1, CHK_NO_FIT);
    send_baud(32'd4096, CHK_PREDICT);
    send_baud(32'd268_435_455, CHK_PREDICT);
    send_baud(32'h8000_0000, CHK_NO_FIT);
    send_baud(32'd3_000_000, CHK_PREDICT);

    // Random phases across clocks and idle patterns
    clocks = '{32'd12_000_000, 32'd1, 32'd48_000_000, 32'hFFFF_FFFF, 32'd0, 32'd100_000};
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 31 : (ph == 1) ? 69 : 0;
      recv_idle_pct = (ph == 0) ? 69 : (ph == 1) ? 31 : 0;
      for (int c = 0; c < 6; c++) begin
        set_clock((c == 5) ? $urandom() : clocks[c]);
        n = (c == 0 || c == 5) ? 150 : 80;
        for (int k = 0; k < n; k++) begin
          send_baud(rand_baud(), CHK_PREDICT);
          // Hold off the sender until the pipeline has emptied
          if (k == 40) begin
            in_valid <= 1'b0;
            while (pending_picks.size() != 0) @(negedge clk);
          end
        end
      end
    end

    in_valid <= 1'b0;
    while (pending_picks.size() != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
    if (fail_count == 0)
      $display("** uart_baud_divisor_search: PASSED **");
    else
      $display("** uart_baud_divisor_search: FAILED **");
    $finish;
  end

endmodule
